@@ rtl/swsd_pkg.sv @@
`timescale 1ns / 1ps

package swsd_pkg;

    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned SYNC_W    = 32;
    localparam int unsigned COUNT_W   = 5;
    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned CHAN_W    = 4;
    localparam int unsigned FRAME_W   = 32;
    localparam int unsigned SYNC_BYTES = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_PATTERN  = 8'd0,
        CFG_CHANNEL_COUNT = 8'd1,
        CFG_SAMPLE_TYPE   = 8'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_U8  = 3'd0,
        ST_U16 = 3'd1,
        ST_U32 = 3'd2,
        ST_S8  = 3'd3,
        ST_S16 = 3'd4,
        ST_S32 = 3'd5,
        ST_F32 = 3'd6,
        ST_F64 = 3'd7
    } t_sample_type;

    typedef struct packed {
        logic               done;
        logic               last;
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
        logic [FRAME_W-1:0] frame;
    } t_sample_res;

    // bytes per sample
    function automatic logic [3:0] sample_size(input t_sample_type st);
        logic [3:0] sz;
        unique case (st)
            ST_U8, ST_S8:   sz = 4'd1;
            ST_U16, ST_S16: sz = 4'd2;
            ST_F64:         sz = 4'd8;
            default:        sz = 4'd4;
        endcase
        return sz;
    endfunction

    function automatic logic [VALUE_W-1:0] extend_sample(input logic [VALUE_W-1:0] raw,
                                                         input t_sample_type st);
        logic [VALUE_W-1:0] v;
        unique case (st)
            ST_U8:          v = {56'd0, raw[7:0]};
            ST_U16:         v = {48'd0, raw[15:0]};
            ST_U32, ST_F32: v = {32'd0, raw[31:0]};
            ST_S8:          v = {{56{raw[7]}}, raw[7:0]};
            ST_S16:         v = {{48{raw[15]}}, raw[15:0]};
            ST_S32:         v = {{32{raw[31]}}, raw[31:0]};
            default:        v = raw;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/swsd_matcher.sv @@
`timescale 1ns / 1ps

module swsd_matcher
    import swsd_pkg::*;
#(
    parameter int unsigned HEADER_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic [SYNC_W-1:0] i_sync_pattern,
    output logic              o_hdr_done
);

    localparam int unsigned HW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

    logic [HW-1:0] r_pos;
    logic [HW-1:0] n_pos;
    logic [HW-1:0] pos_a;
    logic [HW:0]   pos_b;

    function automatic logic [7:0] expected_byte(input logic [HW-1:0] pos,
                                                 input logic [SYNC_W-1:0] pat);
        logic [7:0] e;
        e = 8'd0;
        for (int k = 0; k < SYNC_BYTES; k++) begin
            if (HW'(k) == pos && k < HEADER_BYTES) begin
                e = pat[8*k +: 8];
            end
        end
        return e;
    endfunction

    // restart on mismatch: the same byte is retried against the first sync byte
    always_comb begin
        pos_a = (i_byte != expected_byte(r_pos, i_sync_pattern)) ? '0 : r_pos;
        if (i_byte == expected_byte(pos_a, i_sync_pattern)) begin
            pos_b = {1'b0, pos_a} + 1'b1;
        end else begin
            pos_b = '0;
        end
        o_hdr_done = i_step && (pos_b >= (HW+1)'(HEADER_BYTES));
        if (!i_step) begin
            n_pos = r_pos;
        end else if (o_hdr_done) begin
            n_pos = '0;
        end else begin
            n_pos = pos_b[HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    a_done_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hdr_done |=> r_pos == '0)
        else $error("matcher did not restart after full header");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_pos))
        else $error("match position moved without a byte");

endmodule

@@ rtl/swsd_assembler.sv @@
`timescale 1ns / 1ps

module swsd_assembler
    import swsd_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  t_sample_type       i_sample_type,
    input  logic [COUNT_W-1:0] i_channel_count,
    output t_sample_res        o_res
);

    localparam int unsigned CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned NW   = ($clog2(MAX_CHANNELS + 1) > COUNT_W) ?
                                   $clog2(MAX_CHANNELS + 1) : COUNT_W;

    logic [2:0]         r_bis;
    logic [2:0]         n_bis;
    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] n_acc;
    logic [CH_W-1:0]    r_ch;
    logic [CH_W-1:0]    n_ch;
    logic [FRAME_W-1:0] r_frame;
    logic [FRAME_W-1:0] n_frame;

    logic [VALUE_W-1:0] acc_new;
    logic [3:0]         bis_inc;
    logic [NW-1:0]      cnt_ext;
    logic [NW-1:0]      n_eff;
    logic [NW-1:0]      ch_plus;
    logic               done;
    logic               last;

    always_comb begin
        acc_new = r_acc | (VALUE_W'(i_byte) << {r_bis, 3'b000});
        bis_inc = {1'b0, r_bis} + 4'd1;
        done    = i_step && (bis_inc >= sample_size(i_sample_type));

        cnt_ext = NW'(i_channel_count);
        if (cnt_ext == '0) begin
            n_eff = NW'(1);
        end else if (cnt_ext > NW'(MAX_CHANNELS)) begin
            n_eff = NW'(MAX_CHANNELS);
        end else begin
            n_eff = cnt_ext;
        end
        ch_plus = NW'(r_ch) + NW'(1);
        last    = ch_plus >= n_eff;

        o_res.done    = done;
        o_res.last    = last;
        o_res.channel = CHAN_W'(r_ch);
        o_res.value   = extend_sample(acc_new, i_sample_type);
        o_res.frame   = r_frame;
    end

    always_comb begin
        n_bis   = r_bis;
        n_acc   = r_acc;
        n_ch    = r_ch;
        n_frame = r_frame;
        priority if (i_start) begin
            n_bis = '0;
            n_acc = '0;
            n_ch  = '0;
        end else if (done) begin
            n_bis = '0;
            n_acc = '0;
            if (last) begin
                n_ch    = '0;
                n_frame = r_frame + 1'b1;
            end else begin
                n_ch = CH_W'(ch_plus);
            end
        end else if (i_step) begin
            n_bis = bis_inc[2:0];
            n_acc = acc_new;
        end else begin
            // no byte this cycle
            n_bis = r_bis;
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bis   <= '0;
            r_acc   <= '0;
            r_ch    <= '0;
            r_frame <= '0;
        end else begin
            r_bis   <= n_bis;
            r_acc   <= n_acc;
            r_ch    <= n_ch;
            r_frame <= n_frame;
        end
    end

    a_frame_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && last && !i_start) |=> r_frame == $past(r_frame) + 1'b1)
        else $error("frame counter did not advance on last sample");

    a_acc_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_step && !i_start) |=> $stable(r_acc) && $stable(r_ch))
        else $error("sample state moved without a byte");

endmodule

@@ rtl/sync_word_sample_deframer_top.sv @@
`timescale 1ns / 1ps

// channel   valid        ready        payload
// input     i_in_valid   o_in_ready   i_rx_byte
// output    o_out_valid  i_out_ready  o_channel, o_sample_value, o_frame_last, o_frame_number
// config    i_cfg_valid  o_cfg_ready  i_cfg_index, i_cfg_data
//
// one byte per cycle while o_in_ready; a result appears in the cycle after its last byte
// results pass through the single output register after the matcher and accumulator
// reset (i_rst_n low, synchronous) clears state and loads register defaults
// o_in_ready drops only while a result is held and i_out_ready is low
// config port is always ready; writes take effect on the next byte

module sync_word_sample_deframer_top
    import swsd_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = 16,
    parameter int unsigned HEADER_BYTES = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CHAN_W-1:0]    o_channel,
    output logic [VALUE_W-1:0]   o_sample_value,
    output logic                 o_frame_last,
    output logic [FRAME_W-1:0]   o_frame_number,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SYNC_W-1:0]    i_cfg_data
);

    logic [SYNC_W-1:0]  r_sync_pattern;
    logic [COUNT_W-1:0] r_channel_count;
    t_sample_type       r_sample_type;
    logic               r_in_payload;
    logic               n_in_payload;

    logic               r_out_valid;
    logic               n_out_valid;
    logic [CHAN_W-1:0]  r_channel;
    logic [VALUE_W-1:0] r_sample_value;
    logic               r_frame_last;
    logic [FRAME_W-1:0] r_frame_number;

    logic               in_accept;
    logic               hdr_done;
    t_sample_res        res;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    swsd_matcher #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_matcher (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_accept && !r_in_payload),
        .i_byte         (i_rx_byte),
        .i_sync_pattern (r_sync_pattern),
        .o_hdr_done     (hdr_done)
    );

    swsd_assembler #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_assembler (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (hdr_done),
        .i_step          (in_accept && r_in_payload),
        .i_byte          (i_rx_byte),
        .i_sample_type   (r_sample_type),
        .i_channel_count (r_channel_count),
        .o_res           (res)
    );

    always_comb begin
        n_in_payload = r_in_payload;
        // header match only while hunting, sample completion only in payload
        if (hdr_done) begin
            n_in_payload = 1'b1;
        end else if (res.done && res.last) begin
            n_in_payload = 1'b0;
        end
        n_out_valid = r_out_valid && !i_out_ready;
        if (res.done) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pattern  <= '0;
            r_channel_count <= COUNT_W'(1);
            r_sample_type   <= ST_U8;
            r_in_payload    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_in_payload <= n_in_payload;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SYNC_PATTERN:  r_sync_pattern  <= i_cfg_data;
                    CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_SAMPLE_TYPE:   r_sample_type   <= t_sample_type'(i_cfg_data[2:0]);
                    default: ;
                endcase
            end
        end
    end

    // result payload, loaded only when a sample completes
    always_ff @(posedge i_clk) begin
        if (res.done) begin
            r_channel      <= res.channel;
            r_sample_value <= res.value;
            r_frame_last   <= res.last;
            r_frame_number <= res.frame;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_channel      = r_channel;
    assign o_sample_value = r_sample_value;
    assign o_frame_last   = r_frame_last;
    assign o_frame_number = r_frame_number;

    a_hunt_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !r_in_payload) |=> r_out_valid == $past(r_out_valid && !i_out_ready))
        else $error("result produced while hunting for sync");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.done && res.last) |=> !r_in_payload)
        else $error("payload mode kept after last sample");

endmodule

@@ tb/tb_sync_word_sample_deframer_top.sv @@
`timescale 1ns / 1ps

module tb_sync_word_sample_deframer_top;
    import swsd_pkg::*;

    localparam int unsigned MAX_CH       = 16;
    localparam int unsigned HDR_LEN      = 4;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned LIMIT_CYCLES = 1000000;
    localparam int unsigned MAX_PRINTS   = 40;

    typedef struct {
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic [FRAME_W-1:0] frame;
    } t_deframed_sample;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [7:0]           i_rx_byte = 8'd0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [CHAN_W-1:0]    o_channel;
    logic [VALUE_W-1:0]   o_sample_value;
    logic                 o_frame_last;
    logic [FRAME_W-1:0]   o_frame_number;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SYNC_PATTERN;
    logic [SYNC_W-1:0]    i_cfg_data = '0;

    sync_word_sample_deframer_top #(
        .MAX_CHANNELS(MAX_CH),
        .HEADER_BYTES(HDR_LEN)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_channel      (o_channel),
        .o_sample_value (o_sample_value),
        .o_frame_last   (o_frame_last),
        .o_frame_number (o_frame_number),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register copies
    logic [SYNC_W-1:0]  cur_sync = '0;
    logic [COUNT_W-1:0] cur_count = 5'd1;
    t_sample_type       cur_type = ST_U8;

    // deframer state
    int unsigned        hdr_matched = 0;
    bit                 in_frame = 1'b0;
    int unsigned        byte_pos = 0;
    logic [VALUE_W-1:0] sample_accum = '0;
    int unsigned        chan_idx = 0;
    logic [FRAME_W-1:0] frames_done = '0;

    t_deframed_sample   expected_samples[$];
    int unsigned        mismatch_cnt = 0;
    int unsigned        rx_count = 0;
    int unsigned        cycle_cnt = 0;
    int unsigned        sink_hold = 0;
    bit                 src_idle = 1'b1;
    bit                 sink_idle = 1'b1;

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] sync_byte(input int unsigned pos);
        if (pos >= 4) return 8'h00;
        return cur_sync[8*pos +: 8];
    endfunction

    function automatic int unsigned bytes_per_sample(input t_sample_type st);
        case (st)
            ST_U8, ST_S8:   return 1;
            ST_U16, ST_S16: return 2;
            ST_F64:         return 8;
            default:        return 4;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] widen_sample(input logic [VALUE_W-1:0] raw,
                                                        input t_sample_type st);
        case (st)
            ST_U8:          return 64'(raw[7:0]);
            ST_U16:         return 64'(raw[15:0]);
            ST_U32, ST_F32: return 64'(raw[31:0]);
            ST_S8:          return 64'($signed(raw[7:0]));
            ST_S16:         return 64'($signed(raw[15:0]));
            ST_S32:         return 64'($signed(raw[31:0]));
            default:        return raw;
        endcase
    endfunction

    function automatic int unsigned active_channels();
        if (cur_count == 0) return 1;
        if (cur_count > MAX_CH) return MAX_CH;
        return cur_count;
    endfunction

    // advances the deframer by one byte, queues a sample when one completes
    function automatic void predict_sample(input logic [7:0] b);
        t_deframed_sample s;
        bit               last;
        if (!in_frame) begin
            if (hdr_matched >= HDR_LEN) hdr_matched = 0;
            if (b != sync_byte(hdr_matched)) hdr_matched = 0;
            if (b == sync_byte(hdr_matched)) hdr_matched++;
            else hdr_matched = 0;
            if (hdr_matched >= HDR_LEN) begin
                in_frame     = 1'b1;
                hdr_matched  = 0;
                byte_pos     = 0;
                sample_accum = '0;
                chan_idx     = 0;
            end
            return;
        end
        byte_pos     = byte_pos & 7;
        sample_accum = sample_accum | (64'(b) << (8 * byte_pos));
        byte_pos++;
        if (byte_pos < bytes_per_sample(cur_type)) return;
        last      = (chan_idx + 1) >= active_channels();
        s.channel = chan_idx[CHAN_W-1:0];
        s.value   = widen_sample(sample_accum, cur_type);
        s.last    = last;
        s.frame   = frames_done;
        expected_samples.push_back(s);
        byte_pos     = 0;
        sample_accum = '0;
        if (last) begin
            chan_idx    = 0;
            frames_done = frames_done + 1;
            in_frame    = 1'b0;
        end else begin
            chan_idx++;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTS)
            $display("%0t mismatch %s: expected %h got %h", $time, what, want, got);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = src_idle ? gap_len() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        predict_sample(b);
        rx_count++;
    endtask

    // wait until every queued sample came out, then let the pipeline drain
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [SYNC_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SYNC_PATTERN:  cur_sync  = data;
            CFG_CHANNEL_COUNT: cur_count = data[COUNT_W-1:0];
            CFG_SAMPLE_TYPE:   cur_type  = t_sample_type'(data[2:0]);
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] pat, input logic [31:0] cnt_word,
                              input logic [31:0] type_word);
        settle();
        write_reg(CFG_SYNC_PATTERN, pat);
        write_reg(CFG_CHANNEL_COUNT, cnt_word);
        write_reg(CFG_SAMPLE_TYPE, type_word);
    endtask

    task automatic send_header();
        for (int i = 0; i < HDR_LEN; i++) send_byte(sync_byte(i));
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // repeated leading bytes exercise the restart on mismatch
    function automatic logic [31:0] rand_sync();
        logic [7:0] a;
        logic [7:0] c;
        a = 8'($urandom_range(0, 255));
        c = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       return {4{a}};
            1:       return {c, a, a, a};
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [4:0] rand_count();
        if ($urandom_range(0, 9) < 7) return 5'($urandom_range(1, 4));
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic send_random_frame();
        int unsigned nbytes;
        int unsigned k;
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 6)) send_byte(rand_byte());
        // broken header: a partial match followed by a random byte
        if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(1, HDR_LEN - 1);
            for (int i = 0; i < k; i++) send_byte(sync_byte(i));
            send_byte(rand_byte());
        end
        send_header();
        nbytes = active_channels() * bytes_per_sample(cur_type);
        if ($urandom_range(0, 19) == 0) nbytes = $urandom_range(0, nbytes);
        repeat (nbytes) send_byte(rand_byte());
    endtask

    task automatic test_reset_defaults();
        // reset config: zero sync pattern, one channel, u8
        repeat (4) send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_sample_types();
        t_sample_type type_seq [0:6];
        int unsigned  sz;
        type_seq = '{ST_U16, ST_U32, ST_S8, ST_S16, ST_S32, ST_F32, ST_F64};
        settle();
        write_reg(CFG_CHANNEL_COUNT, 32'd7);
        send_header();
        // one frame, type switched between samples
        foreach (type_seq[t]) begin
            settle();
            write_reg(CFG_SAMPLE_TYPE, 32'(type_seq[t]));
            sz = bytes_per_sample(type_seq[t]);
            for (int i = 0; i < sz; i++)
                send_byte((i == sz - 1) ? 8'h81 : 8'(8'h7E - i));
        end
    endtask

    task automatic test_sync_restart();
        set_config(32'hC3A5_A5A5, 32'd1, 32'(ST_U16));
        // fourth a5 breaks the match, then restarts against the first byte
        repeat (4) send_byte(8'hA5);
        send_byte(8'hC3);
        send_header();
        send_byte(8'h34);
        send_byte(8'h12);
    endtask

    task automatic test_type_change_mid_sample();
        set_config(32'h0102_0304, 32'd2, 32'(ST_U32));
        send_header();
        send_byte(8'hF0);
        send_byte(8'h92);
        settle();
        write_reg(CFG_SAMPLE_TYPE, 32'(ST_S8));
        send_byte(8'h33);
        settle();
        write_reg(CFG_SAMPLE_TYPE, 32'(ST_U16));
        send_byte(8'h44);
        send_byte(8'h55);
    endtask

    task automatic test_random_frames();
        int unsigned  start;
        int unsigned  phase_start;
        int unsigned  budget;
        int unsigned  p;
        logic [31:0]  pat;
        logic [4:0]   cnt;
        t_sample_type st;
        logic [31:0]  cnt_word;
        logic [31:0]  type_word;
        start = rx_count;
        p     = 0;
        while (rx_count - start < RANDOM_ITEMS) begin
            case (p)
                0: begin
                    pat = 32'h0000_0000; cnt = 5'd0;  st = ST_U8;
                end
                1: begin
                    pat = 32'hFFFF_FFFF; cnt = 5'd31; st = ST_S8;
                end
                2: begin
                    pat = $urandom();    cnt = 5'd16; st = ST_F64;
                end
                default: begin
                    pat = rand_sync();
                    cnt = rand_count();
                    st  = t_sample_type'($urandom_range(0, 7));
                end
            endcase
            cnt_word  = 32'(cnt);
            type_word = 32'(st);
            // unused upper bits of the narrow registers
            if ($urandom_range(0, 3) == 0) cnt_word  = {27'($urandom()), cnt};
            if ($urandom_range(0, 3) == 0) type_word = {29'($urandom()), 3'(st)};
            settle();
            src_idle  = (p % 3 != 1);
            sink_idle = (p % 4 != 2);
            set_config(pat, cnt_word, type_word);
            budget      = $urandom_range(80, 160);
            phase_start = rx_count;
            while (rx_count - phase_start < budget) send_random_frame();
            p++;
        end
    endtask

    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (!i_out_ready || !sink_idle || $urandom_range(0, 3) != 0) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b0;
            sink_hold   <= gap_len();
        end
    end

    always @(posedge i_clk) begin : check_results
        t_deframed_sample want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("result with nothing expected, channel", '0, 64'(o_channel));
            end else begin
                want = expected_samples.pop_front();
                if (o_channel !== want.channel)
                    report_mismatch("channel", 64'(want.channel), 64'(o_channel));
                if (o_sample_value !== want.value)
                    report_mismatch("sample_value", want.value, o_sample_value);
                if (o_frame_last !== want.last)
                    report_mismatch("frame_last", 64'(want.last), 64'(o_frame_last));
                if (o_frame_number !== want.frame)
                    report_mismatch("frame_number", 64'(want.frame), 64'(o_frame_number));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("tb_sync_word_sample_deframer_top: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_sample_types();
        test_sync_restart();
        test_type_change_mid_sample();
        test_random_frames();

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_samples.size() == 0) begin
            $display("tb_sync_word_sample_deframer_top: clean");
        end else begin
            $display("tb_sync_word_sample_deframer_top: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/swsd_pkg.sv
rtl/swsd_matcher.sv
rtl/swsd_assembler.sv
rtl/sync_word_sample_deframer_top.sv
tb/tb_sync_word_sample_deframer_top.sv
